>>> src/r2fa_pkg.sv
// Shared types and constants for the R2 factor accumulator.
`timescale 1ns / 1ps
package r2fa_pkg;
    localparam int MAX_POINTS  = 4096;
    localparam int SAMPLE_BITS = 16;
    localparam int CNT_W  = $clog2(MAX_POINTS + 1);
    localparam int SQ_W   = 2 * SAMPLE_BITS + CNT_W - 1;
    localparam int ST_W   = SAMPLE_BITS + CNT_W - 1;
    localparam int W      = 128;
    localparam int R_W    = 20;
    localparam logic [R_W-1:0] R_MAX = {R_W{1'b1}};

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_EXP_ZERO = 2'd1;
    localparam logic [1:0] ST_DEN_ZERO = 2'd2;

    typedef struct packed {
        logic [15:0] exp_intensity;
        logic [15:0] theory_intensity;
        logic        last_point;
    } t_in;

    typedef struct packed {
        logic [R_W-1:0] r_factor;
        logic [1:0]     status;
    } t_out;

    typedef struct packed {
        logic [SQ_W-1:0]  see;
        logic [SQ_W-1:0]  stt;
        logic [SQ_W-1:0]  ste;
        logic [ST_W-1:0]  st;
        logic [CNT_W-1:0] n;
    } t_sums;

    typedef enum logic [1:0] {
        OP_MUL  = 2'd0,
        OP_DIV  = 2'd1,
        OP_SQRT = 2'd2
    } t_op;

    typedef struct packed {
        logic start;
        t_op  op;
    } t_iter_req;
endpackage

>>> src/r2fa_front.sv
// Front end: accumulates sample pairs, hands off a sum snapshot per curve.
`timescale 1ns / 1ps
module r2fa_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_accept,
    input  r2fa_pkg::t_in        i_item,
    output logic                 o_push,
    output r2fa_pkg::t_sums      o_sums
);
    localparam int SAMPLE_W = r2fa_pkg::SAMPLE_BITS;
    r2fa_pkg::t_sums r_sums, n_sums;
    logic [SAMPLE_W-1:0] w_e, w_t;
    logic [2*SAMPLE_W-1:0] w_ee, w_tt, w_te;

    assign w_e = i_item.exp_intensity[SAMPLE_W-1:0];
    assign w_t = i_item.theory_intensity[SAMPLE_W-1:0];
    assign w_ee = w_e * w_e;
    assign w_tt = w_t * w_t;
    assign w_te = w_t * w_e;

    always_comb begin
        n_sums = r_sums;
        if (r_sums.n < r2fa_pkg::CNT_W'(r2fa_pkg::MAX_POINTS)) begin
            n_sums.see = r_sums.see + r2fa_pkg::SQ_W'(w_ee);
            n_sums.stt = r_sums.stt + r2fa_pkg::SQ_W'(w_tt);
            n_sums.ste = r_sums.ste + r2fa_pkg::SQ_W'(w_te);
            n_sums.st  = r_sums.st + r2fa_pkg::ST_W'(w_t);
            n_sums.n   = r_sums.n + 1'b1;
        end
    end

    assign o_push = i_accept && i_item.last_point;
    assign o_sums = n_sums;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || o_push) begin
            r_sums <= '0;
        end else if (i_accept) begin
            r_sums <= n_sums;
        end
    end
endmodule

>>> src/r2fa_queue.sv
// Two-entry queue of per-curve sum snapshots between front and back.
`timescale 1ns / 1ps
module r2fa_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  r2fa_pkg::t_sums i_data,
    input  logic            i_pop,
    output logic            o_full,
    output logic            o_empty,
    output r2fa_pkg::t_sums o_data
);
    r2fa_pkg::t_sums r_mem [2];
    logic       r_wptr, r_rptr;
    logic [1:0] r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_data  = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= 1'b0;
            r_rptr <= 1'b0;
            r_cnt  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wptr <= ~r_wptr;
            end
            if (i_pop) begin
                r_rptr <= ~r_rptr;
            end
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
    end
endmodule

>>> src/r2fa_iter.sv
// Shared iterative unit: shift-add multiply, restoring divide, bitwise square root.
`timescale 1ns / 1ps
module r2fa_iter (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  r2fa_pkg::t_iter_req     i_req,
    input  logic [r2fa_pkg::W-1:0]  i_a,
    input  logic [r2fa_pkg::W-1:0]  i_b,
    output logic                    o_done,
    output logic [r2fa_pkg::W-1:0]  o_y
);
    localparam int W = r2fa_pkg::W;
    logic [W-1:0] r_x, r_y, r_z, n_x, n_y, n_z;
    logic [W-1:0] w_rs, w_t;
    logic [6:0]   r_cnt, n_cnt, w_last;
    logic         r_busy, n_busy, r_done, n_done, w_ge;
    r2fa_pkg::t_op r_op, n_op;

    assign w_rs = {r_z[W-2:0], r_x[W-1]};
    assign w_t  = r_y + r_z;
    assign w_last = (r_op == r2fa_pkg::OP_DIV) ? 7'd127 : 7'd63;

    always_comb begin
        n_x = r_x; n_y = r_y; n_z = r_z;
        n_cnt = r_cnt; n_busy = r_busy; n_op = r_op; n_done = 1'b0;
        w_ge = 1'b0;
        if (i_req.start) begin
            n_op = i_req.op;
            n_busy = 1'b1;
            n_cnt = '0;
            n_x = i_a;
            n_y = i_b;
            n_z = '0;
            if (i_req.op == r2fa_pkg::OP_SQRT) begin
                n_y = '0;
                n_z = W'(1) << (W - 2);
            end
        end else if (r_busy) begin
            case (r_op)
                r2fa_pkg::OP_MUL: begin
                    if (r_y[0]) begin
                        n_z = r_z + r_x;
                    end
                    n_x = r_x << 1;
                    n_y = r_y >> 1;
                end
                r2fa_pkg::OP_DIV: begin
                    // x holds the dividend, shifted out as quotient bits shift in
                    w_ge = (w_rs >= r_y);
                    n_z = w_ge ? (w_rs - r_y) : w_rs;
                    n_x = {r_x[W-2:0], w_ge};
                end
                r2fa_pkg::OP_SQRT: begin
                    // x: remainder, y: root, z: current bit
                    if (r_x >= w_t) begin
                        n_x = r_x - w_t;
                        n_y = (r_y >> 1) + r_z;
                    end else begin
                        n_y = r_y >> 1;
                    end
                    n_z = r_z >> 2;
                end
                default: begin
                    n_busy = 1'b0;
                end
            endcase
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == w_last) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_x <= n_x; r_y <= n_y; r_z <= n_z;
        r_cnt <= n_cnt; r_op <= n_op;
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    assign o_done = r_done;
    always_comb begin
        case (r_op)
            r2fa_pkg::OP_MUL:  o_y = r_z;
            r2fa_pkg::OP_DIV:  o_y = r_x;
            r2fa_pkg::OP_SQRT: o_y = r_y;
            default:           o_y = '0;
        endcase
    end
endmodule

>>> src/r2fa_back.sv
// Back end: sequences the per-curve evaluation on the shared iterative unit.
`timescale 1ns / 1ps
module r2fa_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_empty,
    input  r2fa_pkg::t_sums i_sums,
    output logic            o_pop,
    output logic            o_valid,
    output r2fa_pkg::t_out  o_res
);
    localparam int W = r2fa_pkg::W;
    localparam int SQ_W = r2fa_pkg::SQ_W;

    typedef enum logic [8:0] {
        S_IDLE = 9'b000000001,
        S_NST  = 9'b000000010,
        S_ST2  = 9'b000000100,
        S_Q1   = 9'b000001000,
        S_NQ   = 9'b000010000,
        S_PROD = 9'b000100000,
        S_NUMN = 9'b001000000,
        S_Q    = 9'b010000000,
        S_R    = 9'b100000000
    } t_state;

    t_state r_state, n_state;
    r2fa_pkg::t_sums r_s, n_s;
    logic [W-1:0] r_nst, n_nst, r_d, n_d, r_a, n_a, r_b, n_b, w_y, w_top;
    r2fa_pkg::t_iter_req r_req, n_req;
    logic r_valid, n_valid, w_done;
    r2fa_pkg::t_out r_res, n_res;

    r2fa_iter u_iter (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (r_req),
        .i_a     (r_a),
        .i_b     (r_b),
        .o_done  (w_done),
        .o_y     (w_y)
    );

    assign w_top = {{(W - SQ_W - 32){1'b0}}, r_s.stt, 32'b0};
    assign o_pop = (r_state == S_IDLE) && !i_empty;

    always_comb begin
        n_state = r_state; n_s = r_s; n_nst = r_nst; n_d = r_d;
        n_a = r_a; n_b = r_b;
        n_req = '{start: 1'b0, op: r2fa_pkg::OP_MUL};
        n_valid = 1'b0;
        n_res = r_res;
        case (r_state)
            S_IDLE: begin
                if (!i_empty) begin
                    n_s = i_sums;
                    if (i_sums.see == '0) begin
                        n_valid = 1'b1;
                        n_res = '{r_factor: '0, status: r2fa_pkg::ST_EXP_ZERO};
                    end else begin
                        n_a = W'(i_sums.stt);
                        n_b = W'(i_sums.n);
                        n_req = '{start: 1'b1, op: r2fa_pkg::OP_MUL};
                        n_state = S_NST;
                    end
                end
            end
            S_NST: if (w_done) begin
                n_nst = w_y;
                n_a = W'(r_s.st);
                n_b = W'(r_s.st);
                n_req = '{start: 1'b1, op: r2fa_pkg::OP_MUL};
                n_state = S_ST2;
            end
            S_ST2: if (w_done) begin
                if (r_nst <= w_y) begin
                    n_valid = 1'b1;
                    n_res = '{r_factor: '0, status: r2fa_pkg::ST_DEN_ZERO};
                    n_state = S_IDLE;
                end else begin
                    n_d = r_nst - w_y;
                    n_a = {{(W - SQ_W - 64){1'b0}}, r_s.stt, 64'b0};
                    n_b = W'(r_s.see);
                    n_req = '{start: 1'b1, op: r2fa_pkg::OP_DIV};
                    n_state = S_Q1;
                end
            end
            S_Q1: if (w_done) begin
                n_a = w_y;
                n_req = '{start: 1'b1, op: r2fa_pkg::OP_SQRT};
                n_state = S_NQ;
            end
            S_NQ: if (w_done) begin
                n_a = W'(r_s.ste);
                n_b = {64'b0, w_y[63:0]};
                n_req = '{start: 1'b1, op: r2fa_pkg::OP_MUL};
                n_state = S_PROD;
            end
            S_PROD: if (w_done) begin
                if (w_y >= w_top) begin
                    // negative numerator clamps to zero
                    n_valid = 1'b1;
                    n_res = '{r_factor: '0, status: r2fa_pkg::ST_OK};
                    n_state = S_IDLE;
                end else begin
                    n_a = (w_top - w_y) << 1;
                    n_b = W'(r_s.n);
                    n_req = '{start: 1'b1, op: r2fa_pkg::OP_MUL};
                    n_state = S_NUMN;
                end
            end
            S_NUMN: if (w_done) begin
                n_a = w_y;
                n_b = r_d;
                n_req = '{start: 1'b1, op: r2fa_pkg::OP_DIV};
                n_state = S_Q;
            end
            S_Q: if (w_done) begin
                n_a = w_y;
                n_req = '{start: 1'b1, op: r2fa_pkg::OP_SQRT};
                n_state = S_R;
            end
            S_R: if (w_done) begin
                n_valid = 1'b1;
                n_res.status = r2fa_pkg::ST_OK;
                n_res.r_factor = (w_y > W'(r2fa_pkg::R_MAX)) ? r2fa_pkg::R_MAX
                                 : w_y[r2fa_pkg::R_W-1:0];
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_s <= n_s; r_nst <= n_nst; r_d <= n_d;
        r_a <= n_a; r_b <= n_b; r_res <= n_res;
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_req   <= '{start: 1'b0, op: r2fa_pkg::OP_MUL};
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_req   <= n_req;
            r_valid <= n_valid;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;
endmodule

>>> src/r2_factor_accumulator_core.sv
// Top level of the R2 factor accumulator.
`timescale 1ns / 1ps
// An item is taken in any cycle where start is high and busy is low: one sample
// pair per cycle is summed exactly, up to MAX_POINTS pairs per curve. The item
// flagged last closes the curve and its sums go to a two-entry queue; busy rises
// only while both entries are taken. The back end evaluates each curve on one
// shared bit-serial unit (multiply, divide, square root), then shows the result
// for one cycle with o_valid; the receiver cannot stall it.
module r2_factor_accumulator_core (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    output logic           busy,
    input  r2fa_pkg::t_in  i_in,
    output logic           o_valid,
    output r2fa_pkg::t_out o_res
);
    logic w_accept, w_push, w_full, w_empty, w_pop;
    r2fa_pkg::t_sums w_push_sums, w_pop_sums;

    assign busy = w_full;
    assign w_accept = start && !busy;

    r2fa_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (w_accept),
        .i_item   (i_in),
        .o_push   (w_push),
        .o_sums   (w_push_sums)
    );

    r2fa_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_push_sums),
        .i_pop   (w_pop),
        .o_full  (w_full),
        .o_empty (w_empty),
        .o_data  (w_pop_sums)
    );

    r2fa_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (w_empty),
        .i_sums  (w_pop_sums),
        .o_pop   (w_pop),
        .o_valid (o_valid),
        .o_res   (o_res)
    );

    a_no_valid_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid) else $error("result strobe right after reset");
    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_res.status != 2'd3) else $error("bad status");
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_res.status != r2fa_pkg::ST_OK |-> o_res.r_factor == '0)
        else $error("error result with nonzero factor");
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_empty) else $error("pop from empty queue");
endmodule
